>>> rtl/core/icdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icdf_pkg
// Shared type, coefficients and stage counts of the inverse normal CDF core.
// ----------------------------------------------------------------------------
package icdf_pkg;

   // Central branch working value, signed Q.28
   typedef logic signed [35:0] cen_val_type;

   // Stage counts
   localparam int LOG_LAT  = 32;
   localparam int CEN_LAT  = 35;
   localparam int TAIL_LAT = 76;
   localparam int CEN_PAD  = TAIL_LAT - CEN_LAT;

   // Result magnitude width (Q.27)
   localparam int MAG_W = 31;

   // |y| limit of the central branch, Q0.32
   localparam logic [30:0] CENTRAL_MAX = 31'd1803886264;

   // Rational coefficients, decimal scaled by 1e11, rounded to Q.28
   localparam logic [63:0] QA_MUL = 64'd131072;
   localparam logic [63:0] QA_ADD = 64'd24414062;
   localparam logic [63:0] QA_DIV = 64'd48828125;

   localparam logic [63:0] NUM0_MAG = (64'd250662823884 * QA_MUL + QA_ADD) / QA_DIV;
   localparam logic [63:0] NUM1_MAG = (64'd1861500062529 * QA_MUL + QA_ADD) / QA_DIV;
   localparam logic [63:0] NUM2_MAG = (64'd4139119773534 * QA_MUL + QA_ADD) / QA_DIV;
   localparam logic [63:0] NUM3_MAG = (64'd2544106049637 * QA_MUL + QA_ADD) / QA_DIV;
   localparam logic [63:0] DEN0_MAG = (64'd847351093090 * QA_MUL + QA_ADD) / QA_DIV;
   localparam logic [63:0] DEN1_MAG = (64'd2308336743743 * QA_MUL + QA_ADD) / QA_DIV;
   localparam logic [63:0] DEN2_MAG = (64'd2106224101826 * QA_MUL + QA_ADD) / QA_DIV;
   localparam logic [63:0] DEN3_MAG = (64'd313082909833 * QA_MUL + QA_ADD) / QA_DIV;

   localparam cen_val_type NUM_Q28 [4] = '{
      cen_val_type'(NUM0_MAG[35:0]),
      -cen_val_type'(NUM1_MAG[35:0]),
      cen_val_type'(NUM2_MAG[35:0]),
      -cen_val_type'(NUM3_MAG[35:0])
   };
   localparam cen_val_type DEN_Q28 [4] = '{
      -cen_val_type'(DEN0_MAG[35:0]),
      cen_val_type'(DEN1_MAG[35:0]),
      -cen_val_type'(DEN2_MAG[35:0]),
      cen_val_type'(DEN3_MAG[35:0])
   };
   localparam cen_val_type ONE_Q28 = 36'sd268435456;

   // Tail coefficients: 16-digit decimals split in two halves, rounded to Q.32
   localparam logic [63:0] QC_S  = 64'd16777216;
   localparam logic [63:0] QC_D1 = 64'd390625;
   localparam logic [63:0] QC_L  = 64'd65536;
   localparam logic [63:0] QC_R  = 64'd76293945312;
   localparam logic [63:0] QC_D2 = 64'd152587890625;

   localparam logic [63:0] MC0 = (64'd33747548 * QC_S) / QC_D1
      + (((64'd33747548 * QC_S) % QC_D1) * QC_D1 + 64'd22726147 * QC_L + QC_R) / QC_D2;
   localparam logic [63:0] MC1 = (64'd97616901 * QC_S) / QC_D1
      + (((64'd97616901 * QC_S) % QC_D1) * QC_D1 + 64'd90917186 * QC_L + QC_R) / QC_D2;
   localparam logic [63:0] MC2 = (64'd16079797 * QC_S) / QC_D1
      + (((64'd16079797 * QC_S) % QC_D1) * QC_D1 + 64'd14918209 * QC_L + QC_R) / QC_D2;
   localparam logic [63:0] MC3 = (64'd2764388 * QC_S) / QC_D1
      + (((64'd2764388 * QC_S) % QC_D1) * QC_D1 + 64'd10333863 * QC_L + QC_R) / QC_D2;
   localparam logic [63:0] MC4 = (64'd384057 * QC_S) / QC_D1
      + (((64'd384057 * QC_S) % QC_D1) * QC_D1 + 64'd29373609 * QC_L + QC_R) / QC_D2;
   localparam logic [63:0] MC5 = (64'd39518 * QC_S) / QC_D1
      + (((64'd39518 * QC_S) % QC_D1) * QC_D1 + 64'd96511919 * QC_L + QC_R) / QC_D2;
   localparam logic [63:0] MC6 = (64'd3217 * QC_S) / QC_D1
      + (((64'd3217 * QC_S) % QC_D1) * QC_D1 + 64'd67881768 * QC_L + QC_R) / QC_D2;
   localparam logic [63:0] MC7 = (64'd28 * QC_S) / QC_D1
      + (((64'd28 * QC_S) % QC_D1) * QC_D1 + 64'd88167364 * QC_L + QC_R) / QC_D2;
   localparam logic [63:0] MC8 = (64'd39 * QC_S) / QC_D1
      + (((64'd39 * QC_S) % QC_D1) * QC_D1 + 64'd60315187 * QC_L + QC_R) / QC_D2;
   localparam logic [63:0] LN2_FULL = (64'd69314718 * QC_S) / QC_D1
      + (((64'd69314718 * QC_S) % QC_D1) * QC_D1 + 64'd5599453 * QC_L + QC_R) / QC_D2;
   localparam logic [63:0] LG_FULL = (64'd52876637 * QC_S) / QC_D1
      + (((64'd52876637 * QC_S) % QC_D1) * QC_D1 + 64'd29448977 * QC_L + QC_R) / QC_D2;

   localparam logic [35:0] MORO_Q32 [9] = '{
      MC0[35:0], MC1[35:0], MC2[35:0], MC3[35:0], MC4[35:0],
      MC5[35:0], MC6[35:0], MC7[35:0], MC8[35:0]
   };
   localparam logic [31:0] LN2_Q32 = LN2_FULL[31:0];
   // -log2(ln 2) in Q.30
   localparam logic [63:0] LG_LN2_FULL = (LG_FULL + 64'd2) >> 2;
   localparam logic [35:0] LG_LN2_Q30 = LG_LN2_FULL[35:0];

endpackage

>>> rtl/core/icdf_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icdf_log2
// Pipelined log2 of an unsigned integer, Q.30 result, one fraction bit per
// stage by repeated squaring of the normalized mantissa.
// ----------------------------------------------------------------------------
module icdf_log2 #(
   parameter int W = 32
) (
   input  logic                     clock,
   input  logic [W-1:0]             x_in,
   output logic [$clog2(W)+29:0]    log_out
);

   localparam int EW = $clog2(W);
   localparam int RW = EW + 30;

   logic [W-1:0]  x_nz;
   logic [EW-1:0] lead_in;
   logic [W-1:0]  x_ff;
   logic [EW-1:0] lead_ff;
   logic [W-1:0]  x_norm;

   logic [30:0]   m_ff   [0:30];
   logic [RW-1:0] res_ff [0:30];
   logic [30:0]   m_in   [0:29];
   logic [RW-1:0] res_in [0:29];
   logic [61:0]   sq     [0:29];
   logic [31:0]   sq_sh  [0:29];

   assign x_nz = (x_in == '0) ? W'(1) : x_in;

   // top set bit
   always_comb begin
      lead_in = '0;
      for (int i = 0; i < W; i++) begin
         if (x_nz[i]) begin
            lead_in = EW'(i);
         end
      end
   end

   assign x_norm = x_ff << (EW'(W - 1) - lead_ff);

   always_comb begin
      for (int j = 0; j < 30; j++) begin
         sq[j]    = {31'b0, m_ff[j]} * {31'b0, m_ff[j]};
         sq_sh[j] = sq[j][61:30];
         if (sq_sh[j][31]) begin
            m_in[j]   = sq_sh[j][31:1];
            res_in[j] = res_ff[j] | (RW'(1) << (29 - j));
         end else begin
            m_in[j]   = sq_sh[j][30:0];
            res_in[j] = res_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_nz;
      lead_ff   <= lead_in;
      m_ff[0]   <= x_norm[W-1 -: 31];
      res_ff[0] <= {lead_ff, 30'b0};
      for (int j = 0; j < 30; j++) begin
         m_ff[j+1]   <= m_in[j];
         res_ff[j+1] <= res_in[j];
      end
   end

   assign log_out = res_ff[30];

endmodule

>>> rtl/core/icdf_central.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icdf_central
// Central branch: y*N(r)/D(r) with r = y*y. Horner stages, then a restoring
// divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module icdf_central (
   input  logic        clock,
   input  logic [30:0] ay_in,
   output logic [28:0] mag_out,
   output logic        neg_n_out
);

   localparam int QB = 29;

   function automatic icdf_pkg::cen_val_type mul_q32(
      input icdf_pkg::cen_val_type p,
      input logic [29:0]           q
   );
      logic [35:0] ap;
      logic [64:0] prod;
      logic [64:0] rnd;
      logic [35:0] v;
      begin
         ap   = p[35] ? 36'(-p) : 36'(p);
         prod = {30'b0, ap[34:0]} * {35'b0, q};
         rnd  = (prod + 65'd2147483648) >> 32;
         v    = rnd[35:0];
         mul_q32 = p[35] ? -$signed(v) : $signed(v);
      end
   endfunction

   logic [61:0] ay_sq;
   logic [62:0] ay_sq_rnd;

   logic [29:0] r1_ff, r2_ff, r3_ff, r4_ff;
   logic [30:0] ay1_ff, ay2_ff, ay3_ff, ay4_ff, ay5_ff;
   icdf_pkg::cen_val_type n2_ff, n3_ff, n4_ff, n5_ff;
   icdf_pkg::cen_val_type d2_ff, d3_ff, d4_ff, d5_ff;

   icdf_pkg::cen_val_type d_pos;
   icdf_pkg::cen_val_type n_abs;
   logic [62:0] numer;

   logic [34:0]   rem_ff  [0:QB];
   logic [QB-1:0] low_ff  [0:QB];
   logic [34:0]   dd_ff   [0:QB];
   logic [QB-1:0] q_ff    [0:QB];
   logic          negn_ff [0:QB];

   logic [35:0] rem_w  [0:QB-1];
   logic        rem_ge [0:QB-1];
   logic [35:0] rem_d  [0:QB-1];

   assign ay_sq     = {31'b0, ay_in} * {31'b0, ay_in};
   assign ay_sq_rnd = {1'b0, ay_sq} + 63'd2147483648;

   always_comb begin
      d_pos = (d5_ff < 36'sd1) ? 36'sd1 : d5_ff;
      n_abs = n5_ff[35] ? -n5_ff : n5_ff;
      // a*|N| plus half the divisor for round to nearest
      numer = {1'b0, {31'b0, ay5_ff} * {31'b0, n_abs[30:0]}}
            + {29'b0, d_pos[29:0], 4'b0};
   end

   always_comb begin
      for (int k = 0; k < QB; k++) begin
         rem_w[k]  = {rem_ff[k], low_ff[k][QB-1]};
         rem_ge[k] = rem_w[k] >= {1'b0, dd_ff[k]};
         rem_d[k]  = rem_w[k] - {1'b0, dd_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      r1_ff  <= ay_sq_rnd[61:32];
      ay1_ff <= ay_in;

      n2_ff  <= mul_q32(icdf_pkg::NUM_Q28[3], r1_ff) + icdf_pkg::NUM_Q28[2];
      d2_ff  <= mul_q32(icdf_pkg::DEN_Q28[3], r1_ff) + icdf_pkg::DEN_Q28[2];
      r2_ff  <= r1_ff;
      ay2_ff <= ay1_ff;

      n3_ff  <= mul_q32(n2_ff, r2_ff) + icdf_pkg::NUM_Q28[1];
      d3_ff  <= mul_q32(d2_ff, r2_ff) + icdf_pkg::DEN_Q28[1];
      r3_ff  <= r2_ff;
      ay3_ff <= ay2_ff;

      n4_ff  <= mul_q32(n3_ff, r3_ff) + icdf_pkg::NUM_Q28[0];
      d4_ff  <= mul_q32(d3_ff, r3_ff) + icdf_pkg::DEN_Q28[0];
      r4_ff  <= r3_ff;
      ay4_ff <= ay3_ff;

      n5_ff  <= n4_ff;
      d5_ff  <= mul_q32(d4_ff, r4_ff) + icdf_pkg::ONE_Q28;
      ay5_ff <= ay4_ff;

      rem_ff[0]  <= {1'b0, numer[62:QB]};
      low_ff[0]  <= numer[QB-1:0];
      dd_ff[0]   <= {d_pos[29:0], 5'b0};
      q_ff[0]    <= '0;
      negn_ff[0] <= n5_ff[35];

      for (int k = 0; k < QB; k++) begin
         rem_ff[k+1]  <= rem_ge[k] ? rem_d[k][34:0] : rem_w[k][34:0];
         low_ff[k+1]  <= {low_ff[k][QB-2:0], 1'b0};
         dd_ff[k+1]   <= dd_ff[k];
         q_ff[k+1]    <= {q_ff[k][QB-2:0], rem_ge[k]};
         negn_ff[k+1] <= negn_ff[k];
      end
   end

   assign mag_out   = q_ff[QB];
   assign neg_n_out = negn_ff[QB];

endmodule

>>> rtl/core/icdf_tail.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icdf_tail
// Tail branch: t = ln(-ln s) from two pipelined log2 units, then the
// degree-8 polynomial in t, one Horner step per stage.
// ----------------------------------------------------------------------------
module icdf_tail (
   input  logic        clock,
   input  logic [31:0] s_in,
   output logic [30:0] mag_out
);

   logic [34:0] lg_s;
   logic [35:0] a_ff;
   logic [35:0] lg_a;
   logic [35:0] m_full;
   logic [32:0] m_ff;
   logic [64:0] t_prod;
   logic [64:0] t_rnd;

   logic [35:0] v_ff [0:8];
   logic [29:0] t_ff [0:7];
   logic [65:0] vt   [0:7];
   logic [65:0] vt_r [0:7];
   logic [35:0] v_in [0:7];
   logic [36:0] v_rnd;

   icdf_log2 #(.W(32)) u_log_s (
      .clock   (clock),
      .x_in    (s_in),
      .log_out (lg_s)
   );

   icdf_log2 #(.W(36)) u_log_a (
      .clock   (clock),
      .x_in    (a_ff),
      .log_out (lg_a)
   );

   assign m_full = lg_a - {6'd30, 30'b0} - icdf_pkg::LG_LN2_Q30;
   assign t_prod = {32'b0, m_ff} * {33'b0, icdf_pkg::LN2_Q32};
   assign t_rnd  = t_prod + (65'd1 << 34);

   always_comb begin
      for (int h = 0; h < 8; h++) begin
         vt[h]   = {30'b0, v_ff[h]} * {36'b0, t_ff[h]};
         vt_r[h] = (vt[h] + (66'd1 << 26)) >> 27;
         v_in[h] = vt_r[h][35:0] + icdf_pkg::MORO_Q32[7-h];
      end
   end

   assign v_rnd = {1'b0, v_ff[8]} + 37'd16;

   always_ff @(posedge clock) begin
      a_ff    <= {6'd32, 30'b0} - {1'b0, lg_s};
      m_ff    <= m_full[32:0];
      t_ff[0] <= t_rnd[64:35];
      v_ff[0] <= icdf_pkg::MORO_Q32[8];
      for (int h = 0; h < 8; h++) begin
         v_ff[h+1] <= v_in[h];
      end
      for (int h = 0; h < 7; h++) begin
         t_ff[h+1] <= t_ff[h];
      end
      mag_out <= v_rnd[35:5];
   end

endmodule

>>> rtl/core/inverse_normal_cdf_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_normal_cdf_top
// Inverse standard normal CDF (Beasley-Springer-Moro) on Q0.32 samples.
// Each taken word passes input/operand registers, branch pipelines and output register before rsp_strobe rises.
// Throughput: one word per clock; busy stays low, the pipeline never stalls.
// The tail log2/polynomial path sets the depth; the central path is padded.
// Reset (synchronous) clears only the valid and control registers; the receiver cannot stall.
// ----------------------------------------------------------------------------
module inverse_normal_cdf_top #(
   parameter int IN_BITS  = 32,
   parameter int OUT_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [IN_BITS-1:0]         req_uniform_in,
   input  logic                       req_last_in,
   output logic                       rsp_strobe,
   output logic signed [OUT_BITS-1:0] rsp_normal_out,
   output logic                       rsp_last_out
);

   localparam int TL = icdf_pkg::TAIL_LAT;
   localparam int CP = icdf_pkg::CEN_PAD;
   localparam int MW = icdf_pkg::MAG_W;

   typedef struct packed {
      logic valid;
      logic last;
      logic central;
      logic y_neg;
   } ctrl_type;

   logic [31:0] u_red;
   logic        v0_ff;
   logic        last0_ff;
   logic [31:0] u0_ff;

   logic [31:0] u_c;
   logic [30:0] ay_in;
   logic [31:0] s_in;
   logic [30:0] ay1_ff;
   logic [31:0] s1_ff;

   ctrl_type ctrl_ff [0:TL];

   logic [28:0] cen_mag;
   logic        cen_negn;
   logic [28:0] pad_mag_ff  [0:CP-1];
   logic        pad_negn_ff [0:CP-1];
   logic [30:0] tail_mag;

   logic [MW-1:0] sel_mag;
   logic          sel_neg;
   logic [64:0]   mag_ext;
   logic [64:0]   sat_hi;
   logic [64:0]   res;

   logic                rsp_strobe_ff;
   logic [OUT_BITS-1:0] rsp_normal_ff;
   logic                rsp_last_ff;

   assign busy = 1'b0;

   generate
      if (IN_BITS >= 32) begin : g_in_wide
         assign u_red = req_uniform_in[IN_BITS-1 -: 32];
      end else begin : g_in_narrow
         assign u_red = {req_uniform_in, {(32 - IN_BITS){1'b0}}};
      end
   endgenerate

   // zero sample clamps to one LSB
   assign u_c   = (u0_ff == '0) ? 32'd1 : u0_ff;
   assign ay_in = u_c[31] ? u_c[30:0] : 31'(32'h8000_0000 - u_c);
   assign s_in  = u_c[31] ? (32'd0 - u_c) : u_c;

   icdf_central u_central (
      .clock     (clock),
      .ay_in     (ay1_ff),
      .mag_out   (cen_mag),
      .neg_n_out (cen_negn)
   );

   icdf_tail u_tail (
      .clock   (clock),
      .s_in    (s1_ff),
      .mag_out (tail_mag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         for (int i = 0; i <= TL; i++) begin
            ctrl_ff[i] <= '0;
         end
         rsp_strobe_ff <= 1'b0;
      end else begin
         v0_ff      <= start && !busy;
         ctrl_ff[0] <= '{valid: v0_ff, last: last0_ff,
                         central: ay_in <= icdf_pkg::CENTRAL_MAX, y_neg: !u_c[31]};
         for (int i = 0; i < TL; i++) begin
            ctrl_ff[i+1] <= ctrl_ff[i];
         end
         rsp_strobe_ff <= ctrl_ff[TL].valid;
      end
   end

   always_ff @(posedge clock) begin
      last0_ff <= req_last_in;
      u0_ff    <= u_red;
      ay1_ff   <= ay_in;
      s1_ff    <= s_in;
      // align the central result with the tail path
      pad_mag_ff[0]  <= cen_mag;
      pad_negn_ff[0] <= cen_negn;
      for (int i = 1; i < CP; i++) begin
         pad_mag_ff[i]  <= pad_mag_ff[i-1];
         pad_negn_ff[i] <= pad_negn_ff[i-1];
      end
      rsp_normal_ff <= res[OUT_BITS-1:0];
      rsp_last_ff   <= ctrl_ff[TL].last;
   end

   always_comb begin
      if (ctrl_ff[TL].central) begin
         sel_mag = {{(MW - 29){1'b0}}, pad_mag_ff[CP-1]};
         sel_neg = ctrl_ff[TL].y_neg ^ pad_negn_ff[CP-1];
      end else begin
         sel_mag = tail_mag;
         sel_neg = ctrl_ff[TL].y_neg;
      end
      mag_ext = {{(65 - MW){1'b0}}, sel_mag};
      sat_hi  = (65'd1 << (OUT_BITS - 1)) - 65'd1;
      if (mag_ext > sat_hi) begin
         res = sel_neg ? (65'd0 - sat_hi - 65'd1) : sat_hi;
      end else begin
         res = sel_neg ? (65'd0 - mag_ext) : mag_ext;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_normal_out = rsp_normal_ff;
   assign rsp_last_out   = rsp_last_ff;

endmodule

>>> test/inverse_normal_cdf_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_normal_cdf_top_test
// Self-checking bench for the inverse normal CDF core: drives uniform words,
// predicts each quantile in fixed point and compares every strobed result.
// ----------------------------------------------------------------------------
module inverse_normal_cdf_top_test;

   typedef struct packed {
      logic [31:0] uniform;
      logic        last;
   } sample_word_type;

   typedef struct packed {
      logic signed [31:0] normal;
      logic               last;
   } quantile_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_uniform_in = '0;
   logic        req_last_in = 1'b0;
   logic        rsp_strobe;
   logic signed [31:0] rsp_normal_out;
   logic        rsp_last_out;

   sample_word_type   pending_words [$];
   quantile_word_type expected_quantiles [$];
   int error_count = 0;
   int checked_count = 0;
   int idle_percent = 0;
   bit hold_until_drained = 1'b0;
   bit stimulus_done = 1'b0;
   int central_count = 0;
   int tail_count = 0;

   inverse_normal_cdf_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_uniform_in(req_uniform_in), .req_last_in(req_last_in),
      .rsp_strobe(rsp_strobe), .rsp_normal_out(rsp_normal_out),
      .rsp_last_out(rsp_last_out)
   );

   always #5 clock = ~clock;

   function automatic longint signed round_mul_q32(longint signed p, longint unsigned q);
      longint unsigned mp;
      longint unsigned v;
      mp = (p < 0) ? longint'(-p) : longint'(p);
      v = (mp * q + 64'd2147483648) >> 32;
      return (p < 0) ? -longint'(v) : longint'(v);
   endfunction

   function automatic longint unsigned log2_q30(longint unsigned x);
      int e;
      longint unsigned m;
      longint unsigned res;
      if (x == 0) x = 1;
      e = 63;
      while (x[e] == 1'b0) e--;
      m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
      res = longint'(e) << 30;
      for (int i = 29; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            res[i] = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic logic signed [31:0] normal_quantile(logic [31:0] sample);
      longint unsigned u;
      longint signed y;
      longint signed res;
      longint unsigned ay;
      longint unsigned mag;
      longint unsigned r;
      longint unsigned an;
      longint unsigned dd;
      longint unsigned s;
      longint unsigned la;
      longint unsigned lm;
      longint unsigned t;
      longint unsigned v;
      longint signed n;
      longint signed d;
      bit neg;
      u = (sample == 0) ? 64'd1 : {32'd0, sample};
      y = longint'(u) - 64'sd2147483648;
      ay = (y < 0) ? longint'(-y) : longint'(y);
      if (ay <= icdf_pkg::CENTRAL_MAX) begin
         r = (ay * ay + 64'd2147483648) >> 32;
         n = longint'(icdf_pkg::NUM_Q28[3]);
         d = longint'(icdf_pkg::DEN_Q28[3]);
         for (int k = 2; k >= 0; k--)
            n = round_mul_q32(n, r) + longint'(icdf_pkg::NUM_Q28[k]);
         for (int k = 2; k >= 0; k--)
            d = round_mul_q32(d, r) + longint'(icdf_pkg::DEN_Q28[k]);
         d = round_mul_q32(d, r) + longint'(icdf_pkg::ONE_Q28);
         if (d < 1) d = 1;
         an = (n < 0) ? longint'(-n) : longint'(n);
         dd = longint'(d) << 5;
         mag = (ay * an + dd / 2) / dd;
         neg = (y < 0) != (n < 0);
      end else begin
         s = (y < 0) ? u : (64'd4294967296 - u);
         la = (64'd32 << 30) - log2_q30(s);
         lm = log2_q30(la) - (64'd30 << 30) - 64'(icdf_pkg::LG_LN2_Q30);
         t = (lm * 64'(icdf_pkg::LN2_Q32) + (64'd1 << 34)) >> 35;
         v = 64'(icdf_pkg::MORO_Q32[8]);
         for (int k = 7; k >= 0; k--)
            v = ((v * t + (64'd1 << 26)) >> 27) + 64'(icdf_pkg::MORO_Q32[k]);
         mag = (v + 16) >> 5;
         neg = y < 0;
      end
      if (mag > 64'd2147483647) res = neg ? -64'sd2147483648 : 64'sd2147483647;
      else res = neg ? -longint'(mag) : longint'(mag);
      return res[31:0];
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: present a word on the falling edge, or idle at random with start low.
   always @(negedge clock) begin
      if (!reset && !hold_until_drained && pending_words.size() > 0
          && $urandom_range(99, 0) >= idle_percent) begin
         sample_word_type w;
         w = pending_words.pop_front();
         req_uniform_in <= w.uniform;
         req_last_in <= w.last;
         start <= 1'b1;
      end else begin
         start <= 1'b0;
      end
   end

   // Record the expectation of every word taken at this edge.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         quantile_word_type q;
         q.normal = normal_quantile(req_uniform_in);
         q.last = req_last_in;
         expected_quantiles.push_back(q);
         if (req_uniform_in > 32'd2147483648 - 32'd1803886265 &&
             req_uniform_in < 32'd2147483648 + 32'd1803886265)
            central_count++;
         else
            tail_count++;
      end
   end

   // Monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_quantiles.size() == 0) begin
            report_mismatch("unexpected word", rsp_normal_out, 0);
         end else begin
            quantile_word_type q;
            q = expected_quantiles.pop_front();
            if (rsp_normal_out !== q.normal)
               report_mismatch("normal_out", rsp_normal_out, q.normal);
            if (rsp_last_out !== q.last)
               report_mismatch("last_out", rsp_last_out, q.last);
            checked_count++;
         end
      end
   end

   task automatic queue_word(logic [31:0] value);
      sample_word_type w;
      w.uniform = value;
      w.last = 1'($urandom_range(1, 0));
      pending_words.push_back(w);
   endtask

   task automatic drain_words;
      while (pending_words.size() > 0 || expected_quantiles.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [31:0] value;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: ends, clamp of zero, exact half, branch boundaries, bit patterns.
      queue_word(32'h0000_0000);
      queue_word(32'h0000_0001);
      queue_word(32'h0000_0002);
      queue_word(32'hFFFF_FFFF);
      queue_word(32'hFFFF_FFFE);
      queue_word(32'h8000_0000);
      queue_word(32'h7FFF_FFFF);
      queue_word(32'h8000_0001);
      queue_word(32'd2147483648 + 32'd1803886264);
      queue_word(32'd2147483648 + 32'd1803886265);
      queue_word(32'd2147483648 - 32'd1803886264);
      queue_word(32'd2147483648 - 32'd1803886265);
      queue_word(32'h5555_5555);
      queue_word(32'hAAAA_AAAA);
      queue_word(32'h0000_8000);
      queue_word(32'hFFFF_7FFF);
      drain_words();

      // Hold off until every result is back, then run the random phases.
      hold_until_drained = 1'b1;
      repeat (3) @(posedge clock);
      hold_until_drained = 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         idle_percent = (phase == 0) ? 0 : (phase == 1) ? 66 : (phase == 2) ? 0 : 25;
         for (int n = 0; n < 150; n++) begin
            case ($urandom_range(3, 0))
               0: value = $urandom_range(32'hFFFF_FFFF, 0);
               1: value = $urandom_range(32'hFFFF, 0) >> $urandom_range(15, 0);
               2: value = ~($urandom_range(32'hFFFF, 0) >> $urandom_range(15, 0));
               default: value = 32'd2147483648 + $urandom_range(32'd400000000, 0)
                                 - 32'd200000000;
            endcase
            queue_word(value);
         end
         drain_words();
      end
      stimulus_done = 1'b1;
      repeat (100) @(posedge clock);
      $display("checked %0d words: %0d central, %0d tail, under four idling mixes",
               checked_count, central_count, tail_count);
      if (error_count == 0 && expected_quantiles.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> inverse_normal_cdf_top.f
rtl/core/icdf_pkg.sv
rtl/core/icdf_log2.sv
rtl/core/icdf_central.sv
rtl/core/icdf_tail.sv
rtl/core/inverse_normal_cdf_top.sv
test/inverse_normal_cdf_top_test.sv
